/* rtl/pfa_pkg.sv */
package pfa_pkg;

  localparam int NumPagesDefault  = 512;
  localparam int PageShiftDefault = 12;

  localparam int ROW_W         = 32;
  localparam int ROW_IDX_W     = 5;
  localparam int CFG_W         = 10;
  localparam int OWNER_W       = 8;
  localparam int RESULT_ADDR_W = 21;

  localparam logic [CFG_W-1:0] USER_START_RESET = 10'd256;

  localparam logic [1:0] CMD_ALLOC_AT   = 2'd0;
  localparam logic [1:0] CMD_FIRST_FREE = 2'd1;
  localparam logic [1:0] CMD_USER_FREE  = 2'd2;
  localparam logic [1:0] CMD_QUERY      = 2'd3;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_MISALIGNED = 3'd1;
  localparam logic [2:0] STAT_RANGE      = 3'd2;
  localparam logic [2:0] STAT_USED       = 3'd3;
  localparam logic [2:0] STAT_NONE_FREE  = 3'd4;

  typedef struct packed {
    logic [1:0]                command;
    logic [31:0]               page_addr;
    logic signed [OWNER_W-1:0] owner;
  } pfa_in_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [RESULT_ADDR_W-1:0]  result_addr;
    logic signed [OWNER_W-1:0] page_owner;
    logic                      page_in_use;
  } pfa_out_t;

endpackage

/* rtl/physical_page_frame_allocator_unit.sv */
// First-fit page frame allocator. In-use flags are held as 32-page rows in one memory and
// owner tags in a second memory, one entry per page. After reset a clearing pass writes one
// flag row per cycle, during which no item is accepted. An item with a misaligned or
// out-of-range address, or a search whose start lies past the last page, is answered from the
// idle state without a memory read. Other allocate-at and query items read both memories and
// are answered from the look state; a first-free or user-free search reads one flag row per
// step in the scan state, from its start row to the last row at most, since the flag memory
// delivers one row per cycle. One item is in work at a time; a finished result waits in the
// output register while the next item is accepted. A result that is ready while the output
// register is still full is held, and no item is accepted until the output register takes it.
module physical_page_frame_allocator_unit #(
  parameter int NUM_PAGES  = pfa_pkg::NumPagesDefault,
  parameter int PAGE_SHIFT = pfa_pkg::PageShiftDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  pfa_pkg::pfa_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pfa_pkg::pfa_out_t        out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [pfa_pkg::CFG_W-1:0] cfg_data_i
);
  import pfa_pkg::*;

  localparam int NUM_ROWS  = (NUM_PAGES + ROW_W - 1) / ROW_W;
  localparam int ROW_AW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int PNX_W     = ROW_AW + ROW_IDX_W;
  localparam int PN_W      = $clog2(NUM_PAGES);
  localparam int LAST_BITS = NUM_PAGES - (NUM_ROWS - 1) * ROW_W;
  localparam logic [ROW_W-1:0] LAST_MASK = ROW_W'((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(NUM_ROWS - 1);
  localparam logic [32:0] MEM_SIZE = 33'(NUM_PAGES) << PAGE_SHIFT;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  function automatic logic [RESULT_ADDR_W-1:0] page_to_addr(logic [PNX_W-1:0] pn);
    logic [PNX_W+PAGE_SHIFT-1:0] w;
    w = {pn, {PAGE_SHIFT{1'b0}}};
    return RESULT_ADDR_W'(w);
  endfunction

  logic [2:0]                state_q, state_d;
  logic [ROW_AW-1:0]         clr_q, clr_d;
  logic [1:0]                cmd_q, cmd_d;
  logic signed [OWNER_W-1:0] owner_q, owner_d;
  logic [PNX_W-1:0]          pn_q, pn_d;
  logic [ROW_AW-1:0]         row_q, row_d;
  logic [ROW_W-1:0]          mask_q, mask_d;
  pfa_out_t                  res_q, res_d;
  logic [CFG_W-1:0]          user_start_q;
  logic                      out_valid_q, out_valid_d;
  pfa_out_t                  out_q, out_d;

  logic                      flag_we, flag_re;
  logic [ROW_AW-1:0]         flag_waddr, flag_raddr;
  logic [ROW_W-1:0]          flag_wdata, flag_rdata;
  logic                      own_we, own_re;
  logic [PN_W-1:0]           own_waddr, own_raddr;
  logic [OWNER_W-1:0]        own_rdata;

  logic                      slot_free, accept;
  logic                      emit, load;
  pfa_out_t                  emit_res;
  logic                      misaligned, out_range, start_ok;
  logic [31:0]               pn_wide;
  logic [PNX_W-1:0]          pn_x, start_x, pn_s;
  logic [CFG_W-1:0]          start;
  logic [ROW_W-1:0]          free_bits;
  logic                      found;
  logic [ROW_IDX_W-1:0]      found_idx;
  logic                      look_bit;

  pfa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_ROWS),
    .AW    (ROW_AW)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .re_i    (flag_re),
    .raddr_i (flag_raddr),
    .rdata_o (flag_rdata)
  );

  pfa_ram #(
    .WIDTH (OWNER_W),
    .DEPTH (NUM_PAGES),
    .AW    (PN_W)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (owner_q),
    .re_i    (own_re),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  assign free_bits = ~flag_rdata & mask_q & ((row_q == LAST_ROW) ? LAST_MASK : '1);

  pfa_find u_find (
    .free_i  (free_bits),
    .found_o (found),
    .idx_o   (found_idx)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign misaligned = (in_data_i.page_addr[PAGE_SHIFT-1:0] != '0);
  assign out_range  = ({1'b0, in_data_i.page_addr} >= MEM_SIZE);
  assign pn_wide    = in_data_i.page_addr >> PAGE_SHIFT;
  assign pn_x       = PNX_W'(pn_wide);
  assign start      = (in_data_i.command == CMD_FIRST_FREE) ? '0 : user_start_q;
  assign start_ok   = (32'(start) < 32'(NUM_PAGES));
  assign start_x    = PNX_W'(start);
  assign pn_s       = {row_q, found_idx};
  assign look_bit   = flag_rdata[pn_q[ROW_IDX_W-1:0]];

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    owner_d    = owner_q;
    pn_d       = pn_q;
    row_d      = row_q;
    mask_d     = mask_q;
    res_d      = res_q;
    flag_we    = 1'b0;
    flag_waddr = row_q;
    flag_wdata = '0;
    flag_re    = 1'b0;
    flag_raddr = row_q;
    own_we     = 1'b0;
    own_waddr  = pn_q[PN_W-1:0];
    own_re     = 1'b0;
    own_raddr  = pn_x[PN_W-1:0];
    emit       = 1'b0;
    emit_res   = '0;

    unique case (state_q)
      S_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_q;
        clr_d      = clr_q + ROW_AW'(1);
        if (clr_q == LAST_ROW) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_d   = in_data_i.command;
          owner_d = in_data_i.owner;
          if (in_data_i.command == CMD_ALLOC_AT || in_data_i.command == CMD_QUERY) begin
            if (misaligned) begin
              emit            = 1'b1;
              emit_res.status = STAT_MISALIGNED;
            end else if (out_range) begin
              emit            = 1'b1;
              emit_res.status = STAT_RANGE;
            end else begin
              pn_d       = pn_x;
              flag_re    = 1'b1;
              flag_raddr = pn_x[PNX_W-1:ROW_IDX_W];
              own_re     = 1'b1;
              state_d    = S_LOOK;
            end
          end else if (!start_ok) begin
            emit            = 1'b1;
            emit_res.status = STAT_NONE_FREE;
          end else begin
            row_d      = start_x[PNX_W-1:ROW_IDX_W];
            mask_d     = {ROW_W{1'b1}} << start_x[ROW_IDX_W-1:0];
            flag_re    = 1'b1;
            flag_raddr = start_x[PNX_W-1:ROW_IDX_W];
            state_d    = S_SCAN;
          end
        end
      end
      S_LOOK: begin
        emit                 = 1'b1;
        emit_res.result_addr = page_to_addr(pn_q);
        state_d              = S_IDLE;
        if (cmd_q == CMD_QUERY) begin
          emit_res.status      = STAT_OK;
          emit_res.page_owner  = look_bit ? own_rdata : '0;
          emit_res.page_in_use = look_bit;
        end else if (look_bit) begin
          emit_res.status      = STAT_USED;
          emit_res.page_owner  = own_rdata;
          emit_res.page_in_use = 1'b1;
        end else begin
          flag_we              = 1'b1;
          flag_waddr           = pn_q[PNX_W-1:ROW_IDX_W];
          flag_wdata           = flag_rdata | (ROW_W'(1) << pn_q[ROW_IDX_W-1:0]);
          own_we               = 1'b1;
          own_waddr            = pn_q[PN_W-1:0];
          emit_res.status      = STAT_OK;
          emit_res.page_owner  = owner_q;
          emit_res.page_in_use = 1'b1;
        end
      end
      S_SCAN: begin
        if (found) begin
          flag_we              = 1'b1;
          flag_waddr           = row_q;
          flag_wdata           = flag_rdata | (ROW_W'(1) << found_idx);
          own_we               = 1'b1;
          own_waddr            = pn_s[PN_W-1:0];
          emit                 = 1'b1;
          emit_res.status      = STAT_OK;
          emit_res.result_addr = page_to_addr(pn_s);
          emit_res.page_owner  = owner_q;
          emit_res.page_in_use = 1'b1;
          state_d              = S_IDLE;
        end else if (row_q == LAST_ROW) begin
          emit            = 1'b1;
          emit_res.status = STAT_NONE_FREE;
          state_d         = S_IDLE;
        end else begin
          row_d      = row_q + ROW_AW'(1);
          mask_d     = '1;
          flag_re    = 1'b1;
          flag_raddr = row_q + ROW_AW'(1);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit && !slot_free) begin
      res_d   = emit_res;
      state_d = S_DONE;
    end
  end

  assign load = slot_free && (emit || (state_q == S_DONE));

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = (state_q == S_DONE) ? res_q : emit_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      user_start_q <= USER_START_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        user_start_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    owner_q <= owner_d;
    pn_q    <= pn_d;
    row_q   <= row_d;
    mask_q  <= mask_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/pfa_ram.sv */
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pfa_find.sv */
module pfa_find (
  input  logic [pfa_pkg::ROW_W-1:0]     free_i,
  output logic                          found_o,
  output logic [pfa_pkg::ROW_IDX_W-1:0] idx_o
);
  import pfa_pkg::*;

  always_comb begin
    idx_o = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (free_i[i]) begin
        idx_o = ROW_IDX_W'(i);
      end
    end
  end

  assign found_o = |free_i;

endmodule

/* tb/tb_physical_page_frame_allocator_unit.sv */
module tb_physical_page_frame_allocator_unit;
  import pfa_pkg::*;

  localparam int NUM_PAGES = NumPagesDefault;
  localparam int PAGE_SHIFT = PageShiftDefault;
  localparam longint MEM_BYTES = longint'(NUM_PAGES) << PAGE_SHIFT;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 190;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    pfa_in_t  item;
    bit       typed;
    pfa_out_t want;
  } frame_case_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready_o;
  pfa_in_t in_data;
  logic out_valid_o;
  logic out_ready;
  pfa_out_t out_data_o;
  logic cfg_valid;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data;

  logic frame_busy [NUM_PAGES];
  logic [OWNER_W-1:0] frame_owner [NUM_PAGES];
  logic [CFG_W-1:0] user_start;
  int frames_claimed;

  pfa_out_t reply_q [$];
  frame_case_t directed_rows [$];
  int calm_left [2];
  bit hold_req;
  int fail_count;
  int requests_sent;
  int replies_checked;
  int cfg_writes;
  int status_seen [8];
  int quiet_cycles;

  physical_page_frame_allocator_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic pfa_out_t frame_report(input logic [2:0] status, input int pn);
    pfa_out_t r;
    r = '0;
    r.status = status;
    r.result_addr = RESULT_ADDR_W'(longint'(pn) << PAGE_SHIFT);
    r.page_owner = frame_owner[pn];
    r.page_in_use = frame_busy[pn];
    return r;
  endfunction

  function automatic pfa_out_t predict_allocation(input pfa_in_t item);
    pfa_out_t r;
    int pn;
    int start;
    r = '0;
    if (item.command == CMD_ALLOC_AT || item.command == CMD_QUERY) begin
      if (item.page_addr[PAGE_SHIFT-1:0] != '0) begin
        r.status = STAT_MISALIGNED;
        return r;
      end
      if (longint'(item.page_addr) >= MEM_BYTES) begin
        r.status = STAT_RANGE;
        return r;
      end
      pn = int'(item.page_addr >> PAGE_SHIFT);
      if (item.command == CMD_QUERY) return frame_report(STAT_OK, pn);
      if (frame_busy[pn]) return frame_report(STAT_USED, pn);
    end else begin
      start = (item.command == CMD_FIRST_FREE) ? 0 : int'(user_start);
      pn = NUM_PAGES;
      for (int p = NUM_PAGES - 1; p >= start; p--) begin
        if (!frame_busy[p]) pn = p;
      end
      if (pn >= NUM_PAGES) begin
        r.status = STAT_NONE_FREE;
        return r;
      end
    end
    frame_busy[pn] = 1'b1;
    frame_owner[pn] = item.owner;
    frames_claimed++;
    return frame_report(STAT_OK, pn);
  endfunction

  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic pfa_in_t random_request();
    pfa_in_t item;
    int roll;
    roll = $urandom_range(0, 99);
    item.owner = OWNER_W'($urandom_range(0, 129) - 2);
    if (roll < 45) item.command = CMD_QUERY;
    else if (roll < 70) item.command = CMD_ALLOC_AT;
    else if (roll < 85) item.command = CMD_FIRST_FREE;
    else item.command = CMD_USER_FREE;
    case ($urandom_range(0, 9))
      0: item.page_addr = $urandom;
      1: item.page_addr = ($urandom & 32'hFFFF_F000) | 32'h0020_0000;
      2: item.page_addr = (32'($urandom_range(0, NUM_PAGES - 1)) << PAGE_SHIFT)
                          | 32'($urandom_range(1, (1 << PAGE_SHIFT) - 1));
      default: item.page_addr = 32'($urandom_range(0, NUM_PAGES - 1)) << PAGE_SHIFT;
    endcase
    return item;
  endfunction

  task automatic offer_request(input pfa_in_t item, input bit typed, input pfa_out_t want);
    int gap;
    pfa_out_t predicted;
    gap = draw_wait(0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready_o);
    predicted = predict_allocation(item);
    reply_q.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  task automatic write_user_start(input logic [CFG_W-1:0] value);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready_o);
    user_start = value;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_ready && out_valid_o) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout after %0d cycles without progress", QUIET_LIMIT);
      $display("physical_page_frame_allocator_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : reply_checker
    int stall;
    pfa_out_t want;
    pfa_out_t got;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_wait(1);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid_o);
      got = out_data_o;
      replies_checked++;
      status_seen[got.status]++;
      if (reply_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("reply with nothing pending: %p", got);
      end else begin
        want = reply_q.pop_front();
        if (got.status !== want.status || got.result_addr !== want.result_addr ||
            got.page_owner !== want.page_owner || got.page_in_use !== want.page_in_use) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("reply %0d differs: status %0d/%0d addr %h/%h owner %0d/%0d used %b/%b",
                     replies_checked, want.status, got.status, want.result_addr,
                     got.result_addr, want.page_owner, got.page_owner,
                     want.page_in_use, got.page_in_use);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] start_plan [6];
    pfa_in_t item;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_req = 1'b0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      frame_busy[p] = 1'b0;
      frame_owner[p] = '0;
    end
    user_start = USER_START_RESET;

    directed_rows.push_back('{{CMD_QUERY, 32'h0000_0000, 8'h00}, 1'b1,
                              {STAT_OK, 21'h0, 8'h00, 1'b0}});
    directed_rows.push_back('{{CMD_QUERY, 32'h0000_0001, 8'h00}, 1'b1,
                              {STAT_MISALIGNED, 21'h0, 8'h00, 1'b0}});
    directed_rows.push_back('{{CMD_QUERY, 32'hFFFF_FFFF, 8'h00}, 1'b1,
                              {STAT_MISALIGNED, 21'h0, 8'h00, 1'b0}});
    directed_rows.push_back('{{CMD_QUERY, 32'h0020_0000, 8'h00}, 1'b1,
                              {STAT_RANGE, 21'h0, 8'h00, 1'b0}});
    directed_rows.push_back('{{CMD_ALLOC_AT, 32'hFFFF_F000, 8'h05}, 1'b1,
                              {STAT_RANGE, 21'h0, 8'h00, 1'b0}});
    directed_rows.push_back('{{CMD_ALLOC_AT, 32'h0000_0800, 8'h05}, 1'b1,
                              {STAT_MISALIGNED, 21'h0, 8'h00, 1'b0}});
    directed_rows.push_back('{{CMD_ALLOC_AT, 32'h0000_0000, 8'hFE}, 1'b1,
                              {STAT_OK, 21'h0, 8'hFE, 1'b1}});
    directed_rows.push_back('{{CMD_ALLOC_AT, 32'h0000_0000, 8'h07}, 1'b1,
                              {STAT_USED, 21'h0, 8'hFE, 1'b1}});
    directed_rows.push_back('{{CMD_ALLOC_AT, 32'h0000_1000, 8'hFF}, 1'b1,
                              {STAT_OK, 21'h001000, 8'hFF, 1'b1}});
    directed_rows.push_back('{{CMD_FIRST_FREE, 32'h0000_0000, 8'h03}, 1'b0, '0});
    directed_rows.push_back('{{CMD_USER_FREE, 32'hFFFF_FFFF, 8'h7F}, 1'b0, '0});
    directed_rows.push_back('{{CMD_ALLOC_AT, 32'h001F_F000, 8'h7F}, 1'b1,
                              {STAT_OK, 21'h1FF000, 8'h7F, 1'b1}});
    directed_rows.push_back('{{CMD_QUERY, 32'h001F_F000, 8'h00}, 1'b0, '0});
    directed_rows.push_back('{{CMD_QUERY, 32'h001F_E000, 8'h00}, 1'b0, '0});
    directed_rows.push_back('{{CMD_ALLOC_AT, 32'h0010_0000, 8'h09}, 1'b1,
                              {STAT_USED, 21'h100000, 8'h7F, 1'b1}});
    directed_rows.push_back('{{CMD_USER_FREE, 32'h0000_0000, 8'h00}, 1'b0, '0});
    directed_rows.push_back('{{CMD_FIRST_FREE, 32'h0000_0000, 8'hFE}, 1'b0, '0});
    directed_rows.push_back('{{CMD_QUERY, 32'h0000_0FFF, 8'h00}, 1'b1,
                              {STAT_MISALIGNED, 21'h0, 8'h00, 1'b0}});
    directed_rows.push_back('{{CMD_ALLOC_AT, 32'h7FFF_F000, 8'h01}, 1'b1,
                              {STAT_RANGE, 21'h0, 8'h00, 1'b0}});
    directed_rows.push_back('{{CMD_QUERY, 32'h0000_1000, 8'h00}, 1'b0, '0});

    start_plan[0] = 10'd0;
    start_plan[1] = 10'd512;
    start_plan[2] = 10'd511;
    start_plan[3] = 10'd1;
    start_plan[4] = CFG_W'($urandom_range(2, 510));
    start_plan[5] = USER_START_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_user_start(start_plan[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 60) hold_req = 1'b1;
        if (ph == 2 && n == 80) wait_for_idle();
        offer_request(random_request(), 1'b0, '0);
      end
    end

    // Fill whatever is left so the searches from page zero run dry.
    while (frames_claimed < NUM_PAGES) begin
      item = random_request();
      item.command = CMD_FIRST_FREE;
      offer_request(item, 1'b0, '0);
    end
    repeat (12) offer_request(random_request(), 1'b0, '0);

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests and %0d replies checked, %0d frames claimed, %0d start-page writes",
             requests_sent, replies_checked, frames_claimed, cfg_writes);
    $display({"replies by status: ok %0d, misaligned %0d, out of range %0d, in use %0d, ",
              "none free %0d"},
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_count == 0 && reply_q.size() == 0) begin
      $display("physical_page_frame_allocator_unit: match");
    end else begin
      $display("physical_page_frame_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule
